// ===== design/hdp_pkg.sv =====
package hdp_pkg;

	// Buffer size and derived widths
	localparam int MAX_LEN = 64;
	localparam int AW = $clog2(MAX_LEN);
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int CW = $clog2(MAX_LEN + 16);

	// Grammar codes
	localparam logic [1:0] FMT_ASCTIME = 2'd0;
	localparam logic [1:0] FMT_RFC1123 = 2'd1;
	localparam logic [1:0] FMT_RFC850  = 2'd2;
	localparam logic [1:0] FMT_RESET   = FMT_RFC1123;

	// Two-digit year mapping
	localparam logic [6:0]  YEAR_PIVOT = 7'd70;
	localparam logic [13:0] CENT_NEW   = 14'd2000;
	localparam logic [13:0] CENT_OLD   = 14'd1900;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       last_char;
		logic       local_flag;
	} item_t;

	typedef struct packed {
		logic        valid_res;
		logic        too_long;
		logic [13:0] year;
		logic [3:0]  month;
		logic [6:0]  day;
		logic [6:0]  hours;
		logic [6:0]  minutes;
		logic [6:0]  seconds;
		logic        local_time;
	} result_t;

	// Job descriptor handed from the loader to the parser
	typedef struct packed {
		logic [LW-1:0] len;
		logic          ovf;
		logic          lf;
		logic [1:0]    fmt;
	} job_t;

	// Buffer read request from the parser
	typedef struct packed {
		logic          en;
		logic [AW-1:0] addr;
	} rd_req_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SKIP, ST_SKIPCK, ST_LOAD,
		ST_A_MON0, ST_A_MON1, ST_A_DAY0, ST_B_DAY0, ST_DAY1,
		ST_B_MON0, ST_B_MON1, ST_C_DASH, ST_C_MON, ST_B_Y0,
		ST_YEAR0, ST_YEAR1, ST_YEAR2,
		ST_TIME0, ST_TIME1, ST_TIME2, ST_TIME3, ST_TIME4,
		ST_ZONE0, ST_ZONE1, ST_ZONE2,
		ST_END, ST_FAIL, ST_DONE
	} st_t;

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_spc(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
	endfunction

	function automatic logic [3:0] dval(input logic [7:0] c);
		logic [7:0] d;
		d = c - 8'h30;
		return d[3:0];
	endfunction

	// Month number 1..12, 0 when no name matches
	function automatic logic [3:0] month_of(input logic [23:0] s);
		logic [3:0] m;
		unique case (s)
			"Jan": m = 4'd1;
			"Feb": m = 4'd2;
			"Mar": m = 4'd3;
			"Apr": m = 4'd4;
			"May": m = 4'd5;
			"Jun": m = 4'd6;
			"Jul": m = 4'd7;
			"Aug": m = 4'd8;
			"Sep": m = 4'd9;
			"Oct": m = 4'd10;
			"Nov": m = 4'd11;
			"Dec": m = 4'd12;
			default: m = 4'd0;
		endcase
		return m;
	endfunction

endpackage

// ===== design/http_date_parser.sv =====
// HTTP date parser.
// Items are characters of one date string, presented on item with start;
// an item is taken at a clock edge where start is high and busy is low.
// The item with last_char set ends the string. The grammar comes from the
// date_format register, written through cfg_we/cfg_data (reset: RFC 1123).
// Loading: one character per cycle while busy is low, into a 64-entry
// buffer; longer strings are flagged too_long. After the last character
// busy stays high while the parser walks the buffer through its single
// read port, reading one byte per skipped character and four-byte
// windows for the fields, then done pulses for one cycle with the result.
// busy drops the cycle after done. Only one string is in flight, so
// throughput is one string per load time plus parse time. The receiver
// cannot stall: the result is shown once. Reset clears the loader, the
// queued job and the parser; buffer contents are not cleared, and reads
// past the end of the string are masked to zero.
module http_date_parser import hdp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  item_t      item,
	output logic       busy,
	input  logic       cfg_we,
	input  logic [1:0] cfg_data,
	output logic       done,
	output result_t    result
);

	logic       back_busy;
	logic       pop;
	logic       job_v;
	job_t       job;
	rd_req_t    rd;
	logic [7:0] rd_data;

	hdp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.back_busy (back_busy),
		.pop       (pop),
		.rd        (rd),
		.busy      (busy),
		.job_v     (job_v),
		.job       (job),
		.rd_data_q (rd_data)
	);

	hdp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job_v   (job_v),
		.job     (job),
		.rd_data (rd_data),
		.pop     (pop),
		.rd      (rd),
		.busy    (back_busy),
		.done    (done),
		.result  (result)
	);

endmodule

// ===== design/hdp_front.sv =====
module hdp_front import hdp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  item_t         item,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_data,
	input  logic          back_busy,
	input  logic          pop,
	input  rd_req_t       rd,
	output logic          busy,
	output logic          job_v,
	output job_t          job,
	output logic [7:0]    rd_data_q
);

	logic [7:0]    buf_q [MAX_LEN];
	logic [LW-1:0] cnt_q;
	logic          ovf_q;
	logic [1:0]    fmt_q;
	logic          job_v_q;
	job_t          job_q;
	logic          accept;
	logic          room;

	// Hold off new characters while a string is queued or parsed
	assign busy   = job_v_q || back_busy;
	assign accept = start && !busy;
	assign room   = cnt_q < LW'(MAX_LEN);
	assign job_v  = job_v_q;
	assign job    = job_q;

	// Character buffer: write on accept while there is room, registered read for the parser
	always_ff @(posedge clk) begin
		if (accept && room) begin
			buf_q[cnt_q[AW-1:0]] <= item.char_byte;
		end
		if (rd.en) begin
			rd_data_q <= buf_q[rd.addr];
		end
	end

	// Format register; count characters, track overflow, queue the job on the last one, clear it on pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			fmt_q   <= FMT_RESET;
			job_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				fmt_q <= cfg_data;
			end
			if (pop) begin
				job_v_q <= 1'b0;
			end
			if (accept) begin
				if (item.last_char) begin
					job_v_q <= 1'b1;
					cnt_q   <= '0;
					ovf_q   <= 1'b0;
				end else begin
					cnt_q <= room ? cnt_q + LW'(1) : cnt_q;
					ovf_q <= ovf_q || !room;
				end
			end
		end
	end

	// Capture the job descriptor
	always_ff @(posedge clk) begin
		if (accept && item.last_char) begin
			job_q.len <= room ? cnt_q + LW'(1) : cnt_q;
			job_q.ovf <= ovf_q || !room;
			job_q.lf  <= item.local_flag;
			job_q.fmt <= fmt_q;
		end
	end

endmodule

// ===== design/hdp_back.sv =====
module hdp_back import hdp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_v,
	input  job_t       job,
	input  logic [7:0] rd_data,
	output logic       pop,
	output rd_req_t    rd,
	output logic       busy,
	output logic       done,
	output result_t    result
);

	st_t           st_q, st_d, lret_q, lret_d, sret_q, sret_d;
	logic [CW-1:0] i_q, i_d;
	logic [LW-1:0] len_q, len_d;
	logic [1:0]    fmt_q, fmt_d;
	logic [2:0]    lc_q, lc_d, ln_q, ln_d;
	logic          ssp_q, ssp_d;
	logic          ok_s1;
	logic [7:0]    w_q [4];
	logic [7:0]    w_d [4];
	logic [6:0]    day_q, day_d, h_q, h_d, m_q, m_d, s_q, s_d;
	logic [3:0]    mon_q, mon_d;
	logic [13:0]   yr_q, yr_d;
	logic          sec_q, sec_d, yrok_q, yrok_d, loc_q, loc_d;
	result_t       res_q, res_d;
	logic [CW:0]   la;
	logic          lok;
	logic [3:0]    mnum;
	logic [6:0]    y2;
	logic          date_ok;
	logic [1:0]    widx;

	// Cursor plus k is inside the string
	function automatic logic lt(input logic [CW-1:0] p, input logic [3:0] k,
			input logic [LW-1:0] n);
		return ({1'b0, p} + (CW+1)'(k)) < (CW+1)'(n);
	endfunction

	assign la      = {1'b0, i_q} + (CW+1)'(lc_q);
	assign lok     = la < (CW+1)'(len_q);
	assign mnum    = month_of({w_q[0], w_q[1], w_q[2]});
	assign y2      = 7'(dval(w_q[0])) * 7'd10 + 7'(dval(w_q[1]));
	assign date_ok = (day_q != 7'd0) && sec_q && yrok_q;
	assign widx    = 2'(lc_q - 3'd1);

	// Next state and datapath
	always_comb begin
		st_d   = st_q;
		lret_d = lret_q;
		sret_d = sret_q;
		i_d    = i_q;
		len_d  = len_q;
		fmt_d  = fmt_q;
		lc_d   = lc_q;
		ln_d   = ln_q;
		ssp_d  = ssp_q;
		w_d    = w_q;
		day_d  = day_q;
		mon_d  = mon_q;
		yr_d   = yr_q;
		h_d    = h_q;
		m_d    = m_q;
		s_d    = s_q;
		sec_d  = sec_q;
		yrok_d = yrok_q;
		loc_d  = loc_q;
		res_d  = res_q;
		unique case (st_q)
			ST_IDLE: begin
				if (job_v) begin
					len_d  = job.len;
					fmt_d  = job.fmt;
					day_d  = '0;
					mon_d  = '0;
					yr_d   = '0;
					h_d    = '0;
					m_d    = '0;
					s_d    = '0;
					sec_d  = 1'b0;
					yrok_d = 1'b0;
					loc_d  = (job.fmt == FMT_ASCTIME) ? job.lf : 1'b1;
					res_d  = '0;
					if (job.ovf) begin
						res_d.too_long = 1'b1;
						st_d = ST_DONE;
					end else if (job.fmt == FMT_ASCTIME) begin
						i_d = CW'(4);
						ssp_d = 1'b1;
						sret_d = ST_A_MON0;
						st_d = ST_SKIP;
					end else if (job.fmt == FMT_RFC1123 || job.fmt == FMT_RFC850) begin
						i_d = (job.fmt == FMT_RFC1123) ? CW'(5) : CW'(6);
						ssp_d = 1'b0;
						sret_d = ST_B_DAY0;
						st_d = ST_SKIP;
					end else begin
						st_d = ST_FAIL;
					end
				end
			end
			ST_SKIP: begin
				if (!lt(i_q, 4'd0, len_q)) begin
					st_d = sret_q;
				end else begin
					lc_d = '0;
					ln_d = 3'd1;
					lret_d = ST_SKIPCK;
					st_d = ST_LOAD;
				end
			end
			ST_SKIPCK: begin
				if (ssp_q ? is_spc(w_q[0]) : !is_dig(w_q[0])) begin
					i_d = i_q + CW'(1);
					st_d = ST_SKIP;
				end else begin
					st_d = sret_q;
				end
			end
			ST_LOAD: begin
				if (lc_q != 3'd0) begin
					w_d[widx] = ok_s1 ? rd_data : 8'h00;
				end
				lc_d = lc_q + 3'd1;
				if (lc_q == ln_q) begin
					st_d = lret_q;
				end
			end
			ST_A_MON0: begin
				if (!lt(i_q, 4'd3, len_q)) begin
					st_d = ST_FAIL;
				end else begin
					lc_d = '0;
					ln_d = 3'd4;
					lret_d = ST_A_MON1;
					st_d = ST_LOAD;
				end
			end
			ST_A_MON1: begin
				if (mnum == 4'd0) begin
					st_d = ST_FAIL;
				end else begin
					mon_d = mnum;
					i_d = i_q + CW'(3);
					ssp_d = 1'b0;
					sret_d = ST_A_DAY0;
					st_d = ST_SKIP;
				end
			end
			ST_A_DAY0, ST_B_DAY0: begin
				if (!lt(i_q, (st_q == ST_A_DAY0) ? 4'd7 : 4'd14, len_q)) begin
					st_d = ST_FAIL;
				end else begin
					lc_d = '0;
					ln_d = 3'd4;
					lret_d = ST_DAY1;
					st_d = ST_LOAD;
				end
			end
			ST_DAY1: begin
				if (is_dig(w_q[1])) begin
					day_d = 7'(dval(w_q[0])) * 7'd10 + 7'(dval(w_q[1]));
					i_d = i_q + CW'(2);
				end else begin
					day_d = 7'(dval(w_q[0]));
					i_d = i_q + CW'(1);
				end
				if (fmt_q == FMT_ASCTIME) begin
					st_d = ST_TIME0;
				end else if (fmt_q == FMT_RFC1123) begin
					ssp_d = 1'b1;
					sret_d = ST_B_MON0;
					st_d = ST_SKIP;
				end else begin
					lc_d = '0;
					ln_d = 3'd4;
					lret_d = ST_C_DASH;
					st_d = ST_LOAD;
				end
			end
			ST_B_MON0: begin
				if (!lt(i_q, 4'd11, len_q)) begin
					st_d = ST_FAIL;
				end else begin
					lc_d = '0;
					ln_d = 3'd4;
					lret_d = ST_B_MON1;
					st_d = ST_LOAD;
				end
			end
			ST_B_MON1: begin
				if (mnum == 4'd0) begin
					st_d = ST_FAIL;
				end else begin
					mon_d = mnum;
					i_d = i_q + CW'(3);
					ssp_d = 1'b0;
					sret_d = ST_B_Y0;
					st_d = ST_SKIP;
				end
			end
			ST_C_DASH: begin
				if (w_q[0] != "-") begin
					st_d = ST_FAIL;
				end else begin
					i_d = i_q + CW'(1);
					lc_d = '0;
					ln_d = 3'd4;
					lret_d = ST_C_MON;
					st_d = ST_LOAD;
				end
			end
			ST_C_MON: begin
				if (mnum == 4'd0 || w_q[3] != "-") begin
					st_d = ST_FAIL;
				end else begin
					mon_d = mnum;
					i_d = i_q + CW'(4);
					st_d = ST_B_Y0;
				end
			end
			ST_B_Y0: begin
				st_d = lt(i_q, 4'd7, len_q) ? ST_YEAR0 : ST_FAIL;
			end
			ST_YEAR0: begin
				ssp_d = 1'b0;
				sret_d = ST_YEAR1;
				st_d = ST_SKIP;
			end
			ST_YEAR1: begin
				lc_d = '0;
				ln_d = 3'd4;
				lret_d = ST_YEAR2;
				st_d = ST_LOAD;
			end
			ST_YEAR2: begin
				if (is_dig(w_q[0]) && is_dig(w_q[1])) begin
					yrok_d = 1'b1;
					if (is_dig(w_q[2]) && is_dig(w_q[3])) begin
						yr_d = 14'(dval(w_q[0])) * 14'd1000 + 14'(dval(w_q[1])) * 14'd100
							+ 14'(dval(w_q[2])) * 14'd10 + 14'(dval(w_q[3]));
						i_d = i_q + CW'(4);
					end else begin
						yr_d = 14'(y2) + ((y2 < YEAR_PIVOT) ? CENT_NEW : CENT_OLD);
						i_d = i_q + CW'(2);
					end
				end
				st_d = (fmt_q == FMT_ASCTIME) ? ST_END : ST_TIME0;
			end
			ST_TIME0: begin
				ssp_d = 1'b0;
				sret_d = ST_TIME1;
				st_d = ST_SKIP;
			end
			ST_TIME1: begin
				if (!lt(i_q, 4'd5, len_q)) begin
					st_d = (fmt_q == FMT_ASCTIME) ? ST_YEAR0 : ST_ZONE0;
				end else begin
					lc_d = '0;
					ln_d = 3'd4;
					lret_d = ST_TIME2;
					st_d = ST_LOAD;
				end
			end
			ST_TIME2: begin
				if (is_dig(w_q[1])) begin
					h_d = 7'(dval(w_q[0])) * 7'd10 + 7'(dval(w_q[1]));
					i_d = i_q + CW'(2);
				end else begin
					h_d = 7'(dval(w_q[0]));
					i_d = i_q + CW'(1);
				end
				lc_d = '0;
				ln_d = 3'd4;
				lret_d = ST_TIME3;
				st_d = ST_LOAD;
			end
			ST_TIME3, ST_TIME4: begin
				st_d = (fmt_q == FMT_ASCTIME) ? ST_YEAR0 : ST_ZONE0;
				if (w_q[0] == ":" && is_dig(w_q[1])) begin
					if (is_dig(w_q[2])) begin
						m_d = 7'(dval(w_q[1])) * 7'd10 + 7'(dval(w_q[2]));
						i_d = i_q + CW'(3);
					end else begin
						m_d = 7'(dval(w_q[1]));
						i_d = i_q + CW'(2);
					end
					if (st_q == ST_TIME3) begin
						lc_d = '0;
						ln_d = 3'd4;
						lret_d = ST_TIME4;
						st_d = ST_LOAD;
					end else begin
						m_d = m_q;
						s_d = is_dig(w_q[2]) ?
							7'(dval(w_q[1])) * 7'd10 + 7'(dval(w_q[2])) : 7'(dval(w_q[1]));
						sec_d = 1'b1;
					end
				end
			end
			ST_ZONE0: begin
				if (date_ok) begin
					ssp_d = 1'b1;
					sret_d = ST_ZONE1;
					st_d = ST_SKIP;
				end else begin
					st_d = ST_END;
				end
			end
			ST_ZONE1: begin
				if (lt(i_q, 4'd2, len_q)) begin
					lc_d = '0;
					ln_d = 3'd4;
					lret_d = ST_ZONE2;
					st_d = ST_LOAD;
				end else begin
					st_d = ST_END;
				end
			end
			ST_ZONE2: begin
				loc_d = !(({w_q[0], w_q[1], w_q[2]} == "GMT") ||
					({w_q[0], w_q[1], w_q[2]} == "UTC"));
				st_d = ST_END;
			end
			ST_END: begin
				res_d = '0;
				if (date_ok) begin
					res_d.valid_res  = 1'b1;
					res_d.year       = yr_q;
					res_d.month      = mon_q;
					res_d.day        = day_q;
					res_d.hours      = h_q;
					res_d.minutes    = m_q;
					res_d.seconds    = s_q;
					res_d.local_time = loc_q;
				end
				st_d = ST_DONE;
			end
			ST_FAIL: begin
				res_d = '0;
				st_d = ST_DONE;
			end
			ST_DONE: begin
				st_d = ST_IDLE;
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// Outputs: buffer reads, queue pop, result strobe
	always_comb begin
		rd.en   = (st_q == ST_LOAD) && (lc_q < ln_q);
		rd.addr = la[AW-1:0];
		pop     = (st_q == ST_IDLE) && job_v;
		busy    = (st_q != ST_IDLE);
		done    = (st_q == ST_DONE);
		result  = res_q;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// Cursor, window and fields
	always_ff @(posedge clk) begin
		lret_q <= lret_d;
		sret_q <= sret_d;
		i_q    <= i_d;
		len_q  <= len_d;
		fmt_q  <= fmt_d;
		lc_q   <= lc_d;
		ln_q   <= ln_d;
		ssp_q  <= ssp_d;
		ok_s1  <= lok;
		w_q    <= w_d;
		day_q  <= day_d;
		mon_q  <= mon_d;
		yr_q   <= yr_d;
		h_q    <= h_d;
		m_q    <= m_d;
		s_q    <= s_d;
		sec_q  <= sec_d;
		yrok_q <= yrok_d;
		loc_q  <= loc_d;
		res_q  <= res_d;
	end

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_flag_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.valid_res |-> !result.too_long)
		else $error("valid and too_long together");
	a_load_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_LOAD |-> lc_q <= ln_q) else $error("window load overran");
	a_pop_start: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> busy) else $error("job popped without starting parse");
`endif

endmodule

// ===== test/tb_http_date_parser.sv =====
`timescale 1ns / 100ps

module tb_http_date_parser;
	import hdp_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       start;
	item_t      item;
	logic       busy;
	logic       cfg_we;
	logic [1:0] cfg_data;
	logic       done;
	result_t    result;

	localparam bit [23:0] MONTH_NAMES [12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
		"Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};

	// Predictor state
	logic [1:0] fmt_shadow;
	logic [7:0] line_buf [MAX_LEN];
	int         line_len;
	bit         line_ovf;
	result_t    expected_dates [$];
	int         errors;
	bit         no_idle;
	int         chars_sent;

	http_date_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.done(done),
		.result(result)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Character access past the end reads as zero
	function automatic logic [7:0] ch(int p);
		if (p >= 0 && p < line_len)
			return line_buf[p];
		return 8'd0;
	endfunction

	function automatic bit dig(int p);
		logic [7:0] c;
		c = ch(p);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit spc(int p);
		logic [7:0] c;
		c = ch(p);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic int dv(int p);
		logic [7:0] d;
		d = ch(p) - 8'h30;
		return int'(d);
	endfunction

	function automatic int skip_nd(int p);
		while (p < line_len && !dig(p))
			p++;
		return p;
	endfunction

	function automatic int skip_spc(int p);
		while (p < line_len && spc(p))
			p++;
		return p;
	endfunction

	function automatic int month_at(int p);
		for (int m = 0; m < 12; m++)
			if ({ch(p), ch(p + 1), ch(p + 2)} == MONTH_NAMES[m])
				return m + 1;
		return 0;
	endfunction

	function automatic int scan_year(int p, inout int yr, inout bit found);
		int i;
		int y;
		i = skip_nd(p);
		if (i + 1 < line_len && dig(i) && dig(i + 1)) begin
			if (i + 3 < line_len && dig(i + 2) && dig(i + 3)) begin
				yr = dv(i) * 1000 + dv(i + 1) * 100 + dv(i + 2) * 10 + dv(i + 3);
				i += 4;
			end else begin
				y = dv(i) * 10 + dv(i + 1);
				yr = y + (y < 70 ? 2000 : 1900);
				i += 2;
			end
			found = 1'b1;
		end
		return i;
	endfunction

	function automatic int scan_time(int p, inout int h, inout int mi, inout int s,
			inout bit ok);
		int i;
		i = skip_nd(p);
		if (i + 5 < line_len) begin
			h = dv(i);
			if (dig(i + 1)) begin
				h = h * 10 + dv(i + 1);
				i += 2;
			end else
				i++;
			if (ch(i) == ":" && dig(i + 1)) begin
				mi = dv(i + 1);
				if (dig(i + 2)) begin
					mi = mi * 10 + dv(i + 2);
					i += 3;
				end else
					i += 2;
				if (ch(i) == ":" && i + 1 < line_len && dig(i + 1)) begin
					s = dv(i + 1);
					ok = 1'b1;
					if (i + 2 < line_len && dig(i + 2)) begin
						s = s * 10 + dv(i + 2);
						i += 3;
					end else
						i += 2;
				end
			end
		end
		return i;
	endfunction

	function automatic int scan_day(int i, inout int day);
		day = dv(i);
		if (dig(i + 1)) begin
			day = day * 10 + dv(i + 1);
			return i + 2;
		end
		return i + 1;
	endfunction

	// Parse the buffered string in the given grammar
	function automatic result_t parse_date(logic [1:0] fmt, bit lf_in);
		result_t r;
		int i, day, mon, yr, h, mi, s;
		bit yr_ok, sec_ok, loc;
		bit gmt, utc;
		r = '0;
		day = 0; mon = 0; yr = 0; h = 0; mi = 0; s = 0;
		yr_ok = 0; sec_ok = 0; loc = 1;
		if (fmt == FMT_ASCTIME) begin
			i = skip_spc(4);
			if (!(i + 3 < line_len)) return r;
			mon = month_at(i);
			if (mon == 0) return r;
			i = skip_nd(i + 3);
			if (!(i + 7 < line_len)) return r;
			i = scan_day(i, day);
			i = scan_time(i, h, mi, s, sec_ok);
			i = scan_year(i, yr, yr_ok);
			loc = lf_in;
		end else if (fmt == FMT_RFC1123 || fmt == FMT_RFC850) begin
			i = skip_nd(fmt == FMT_RFC1123 ? 5 : 6);
			if (!(i + 14 < line_len)) return r;
			i = scan_day(i, day);
			if (fmt == FMT_RFC1123) begin
				i = skip_spc(i);
				if (!(i + 11 < line_len)) return r;
				mon = month_at(i);
				if (mon == 0) return r;
				i = skip_nd(i + 3);
			end else begin
				if (ch(i) != "-") return r;
				i++;
				mon = month_at(i);
				if (mon == 0 || ch(i + 3) != "-") return r;
				i += 4;
			end
			if (!(i + 7 < line_len)) return r;
			i = scan_year(i, yr, yr_ok);
			i = scan_time(i, h, mi, s, sec_ok);
			if (day != 0 && sec_ok && yr_ok) begin
				i = skip_spc(i);
				if (i + 2 < line_len) begin
					gmt = {ch(i), ch(i + 1), ch(i + 2)} == "GMT";
					utc = {ch(i), ch(i + 1), ch(i + 2)} == "UTC";
					loc = !(gmt || utc);
				end
			end
		end else
			return r;
		if (!(day != 0 && sec_ok && yr_ok))
			return r;
		r.valid_res = 1'b1;
		r.year = yr[13:0];
		r.month = mon[3:0];
		r.day = day[6:0];
		r.hours = h[6:0];
		r.minutes = mi[6:0];
		r.seconds = s[6:0];
		r.local_time = loc;
		return r;
	endfunction

	// Buffer one accepted item; on the last one queue the expected date
	task automatic predict_date(item_t it);
		result_t r;
		if (line_len < MAX_LEN) begin
			line_buf[line_len] = it.char_byte;
			line_len++;
		end else
			line_ovf = 1'b1;
		if (it.last_char) begin
			if (line_ovf) begin
				r = '0;
				r.too_long = 1'b1;
			end else
				r = parse_date(fmt_shadow, it.local_flag);
			expected_dates.push_back(r);
			line_len = 0;
			line_ovf = 1'b0;
		end
	endtask

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
		errors++;
	endtask

	// Check each date against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (expected_dates.size() == 0)
				report_mismatch("unexpected date", 1, 0);
			else begin
				want = expected_dates.pop_front();
				if (result.valid_res !== want.valid_res)
					report_mismatch("valid_res", result.valid_res, want.valid_res);
				if (result.too_long !== want.too_long)
					report_mismatch("too_long", result.too_long, want.too_long);
				if (result.year !== want.year)
					report_mismatch("year", result.year, want.year);
				if (result.month !== want.month)
					report_mismatch("month", result.month, want.month);
				if (result.day !== want.day)
					report_mismatch("day", result.day, want.day);
				if (result.hours !== want.hours)
					report_mismatch("hours", result.hours, want.hours);
				if (result.minutes !== want.minutes)
					report_mismatch("minutes", result.minutes, want.minutes);
				if (result.seconds !== want.seconds)
					report_mismatch("seconds", result.seconds, want.seconds);
				if (result.local_time !== want.local_time)
					report_mismatch("local_time", result.local_time, want.local_time);
			end
		end
	end

	// Send one item, holding start until the block takes it
	task automatic send_char(logic [7:0] c, bit last, bit lf);
		int gap;
		item_t it;
		gap = no_idle ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.char_byte = c;
		it.last_char = last;
		it.local_flag = lf;
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		predict_date(it);
		chars_sent++;
	endtask

	task automatic send_bytes(byte q [$]);
		no_idle = ($urandom_range(0, 3) == 0);
		if (q.size() == 0)
			q.push_back(byte'($urandom_range(0, 255)));
		foreach (q[k])
			send_char(q[k], k == q.size() - 1, 1'($urandom_range(0, 1)));
	endtask

	task automatic send_text(string s);
		byte q [$];
		for (int k = 0; k < s.len(); k++)
			q.push_back(s[k]);
		send_bytes(q);
	endtask

	// Wait until every date is out and the parser has stopped
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (expected_dates.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_format(logic [1:0] f);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= f;
		fmt_shadow = f;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random date text in one of the three grammars
	function automatic string random_date(int g);
		string wd, mon, d, t, y;
		wd = $sformatf("%c%c%c", $urandom_range(65, 90), $urandom_range(97, 122),
			$urandom_range(97, 122));
		mon = string'(MONTH_NAMES[$urandom_range(0, 11)]);
		if ($urandom_range(0, 9) == 0)
			mon = $sformatf("%c%c%c", $urandom_range(65, 122), $urandom_range(65, 122),
				$urandom_range(65, 122));
		d = $urandom_range(0, 1) ? $sformatf("%02d", $urandom_range(0, 99))
			: $sformatf("%0d", $urandom_range(0, 9));
		t = $urandom_range(0, 3) ? $sformatf("%02d:%02d:%02d", $urandom_range(0, 99),
			$urandom_range(0, 99), $urandom_range(0, 99))
			: $sformatf("%0d:%0d:%0d", $urandom_range(0, 9), $urandom_range(0, 9),
			$urandom_range(0, 9));
		y = $urandom_range(0, 1) ? $sformatf("%04d", $urandom_range(0, 9999))
			: $sformatf("%02d", $urandom_range(0, 99));
		case (g)
			0: return $sformatf("%s %s %s%s %s %s", wd, mon,
				$urandom_range(0, 1) ? " " : "", d, t, y);
			1: return $sformatf("%s, %s %s %s %s %s", wd, d, mon, y, t,
				$urandom_range(0, 2) == 0 ? "UTC" : ($urandom_range(0, 1) ? "GMT" : "PST"));
			default: return $sformatf("%sday, %s-%s-%s %s %s", wd, d, mon, y, t,
				$urandom_range(0, 1) ? "GMT" : "EST");
		endcase
	endfunction

	task automatic test_grammars;
		set_format(FMT_ASCTIME);
		send_text("Sun Nov  6 08:49:37 1994");
		send_text("Mon Jan 1 0:0:0 70");
		send_text("Tue Dec 31 23:59:59 69");
		set_format(FMT_RFC1123);
		send_text("Sun, 06 Nov 1994 08:49:37 GMT");
		send_text("Sat, 99 Dec 9999 99:99:99 UTC");
		send_text("Fri, 01 Feb 0255 01:02:03 CET");
		send_text("Wed, 05\tMar 23 1:2:3 GMT");
		set_format(FMT_RFC850);
		send_text("Sunday, 06-Nov-94 08:49:37 GMT");
		send_text("Monday, 00-Nov-94 08:49:37 GMT");
		send_text("Monday, 10-nov-94 08:49:37 GMT");
		send_text("Tuesday, 10-May-2024 12:00:00 EST");
		set_format(2'd3);
		send_text("Sun, 06 Nov 1994 08:49:37 GMT");
	endtask

	task automatic test_lengths;
		byte q [$];
		string base;
		set_format(FMT_RFC1123);
		send_text("");
		send_text("Sun, 06 Nov 1994 08:49:37");
		send_text("Sun, 06 Nov 1994 08:49 GMT");
		// exactly full buffer, then one past it
		base = "Sun, 06 Nov 1994 08:49:37 GMT";
		for (int n = 64; n <= 65; n++) begin
			q = {};
			for (int k = 0; k < n; k++)
				q.push_back(byte'(k < base.len() ? base[k] : " "));
			send_bytes(q);
		end
		q = {};
		for (int k = 0; k < 90; k++)
			q.push_back(byte'($urandom_range(0, 255)));
		send_bytes(q);
	endtask

	task automatic test_random;
		byte q [$];
		string s;
		int g;
		while (chars_sent < 1450) begin
			if ($urandom_range(0, 9) == 0)
				set_format(2'($urandom_range(0, 3)));
			q = {};
			if ($urandom_range(0, 7) == 0) begin
				// noise
				repeat ($urandom_range(0, 70))
					q.push_back(byte'($urandom_range(0, 255)));
			end else begin
				g = $urandom_range(0, 4) == 0 ? $urandom_range(0, 2) : int'(fmt_shadow);
				s = random_date(g);
				for (int k = 0; k < s.len(); k++)
					q.push_back(s[k]);
				// corrupt or truncate some
				if ($urandom_range(0, 4) == 0)
					q[$urandom_range(0, q.size() - 1)] = byte'($urandom_range(0, 255));
				if ($urandom_range(0, 9) == 0)
					q = q[0:$urandom_range(0, q.size() - 1)];
			end
			send_bytes(q);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_data = FMT_RESET;
		fmt_shadow = FMT_RESET;
		line_len = 0;
		line_ovf = 1'b0;
		errors = 0;
		no_idle = 1'b0;
		chars_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_lengths();
		test_grammars();
		test_random();
		drain();
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Hard stop
	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
design/hdp_pkg.sv
design/hdp_front.sv
design/hdp_back.sv
design/http_date_parser.sv
test/tb_http_date_parser.sv
